/* rtl/fafc_pkg.sv */
// shared types and constants for the fully associative fifo cache unit
// request and response structs, request type codes, default sizes
// no dependencies
package fafc_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int SLOT_W       = 4;
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 32;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic        [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [VAL_W-1:0]  read_value;
    logic        [SLOT_W-1:0] slot;
  } rsp_t;

endpackage

/* rtl/fully_associative_fifo_cache_unit.sv */
// Fully associative key-value cache with first-in first-out replacement.
// One request enters per cycle while in_stall is low and is held in the request
// register, which feeds the compare against all ENTRIES stored keys in parallel
// and the entry update; the result is captured in the response register.
// Sustained rate is one request per clock while out_stall is low, set by the
// parallel comparator row; a stall on the response side holds the response register
// and backs up into in_stall once the request register is also full.
// A put updates the matching entry or replaces the entry at the round-robin
// pointer; a get returns hit, value and slot, or zeros on a miss.
// Depends on fafc_pkg.
module fully_associative_fifo_cache_unit #(
  parameter int ENTRIES  = fafc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = fafc_pkg::DEF_KEY_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fafc_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output fafc_pkg::rsp_t out_rsp
);
  import fafc_pkg::*;

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [KW-1:0]    key_r   [ENTRIES];
  logic [VAL_W-1:0] value_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [IW-1:0]    ptr_r, ptr_nxt;

  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r, rsp_nxt;

  logic          adv, in_accept;
  logic [KW-1:0] key_cmp;
  logic [ENTRIES-1:0] match_vec;
  logic          found;
  logic [IW-1:0] found_idx;
  logic          is_get;

  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign key_cmp = s1_req_r.lookup_key[KW-1:0];
  assign is_get  = (s1_req_r.req_type == REQ_GET);

  // parallel compare, lowest matching index wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (key_r[i] == key_cmp);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
  end

  always_comb begin
    rsp_nxt            = '0;
    ptr_nxt            = ptr_r;
    rsp_nxt.hit        = found;
    if (found) begin
      rsp_nxt.slot = SLOT_W'(found_idx);
      if (is_get) begin
        rsp_nxt.read_value = value_r[found_idx];
      end
    end else if (!is_get) begin
      rsp_nxt.slot = SLOT_W'(ptr_r);
      ptr_nxt      = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
    end
  end

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      ptr_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv && !is_get && !found) begin
        valid_r[ptr_r] <= 1'b1;
        ptr_r          <= ptr_nxt;
      end
    end
  end

  // payload and entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= in_req;
    end
    if (adv) begin
      out_rsp_r <= rsp_nxt;
      if (!is_get) begin
        if (found) begin
          value_r[found_idx] <= s1_req_r.write_value;
        end else begin
          key_r[ptr_r]   <= key_cmp;
          value_r[ptr_r] <= s1_req_r.write_value;
        end
      end
    end
  end

endmodule

/* rtl/fafc_checker.sv */
// port-level checks for the fully associative fifo cache unit
// bound to fully_associative_fifo_cache_unit; depends on fafc_pkg
module fafc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input fafc_pkg::req_t in_req,
  input logic           out_valid,
  input logic           out_stall,
  input fafc_pkg::rsp_t out_rsp
);
  import fafc_pkg::*;

  // a nonzero read value only comes from a hit
  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.read_value != '0) |-> out_rsp.hit)
    else $error("read value without hit");

  // requests are only held back when a response is waiting and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without response backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled response changed");

  // a stalled request stays on the bus unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_req))
    else $error("stalled request changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("response pending after reset");

endmodule

bind fully_associative_fifo_cache_unit fafc_checker u_fafc_checker (.*);
